// ===== rtl/core/can_priority_transmit_cache_core_macros.svh =====
// Assertion macros shared by the transmit cache checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef CAN_PRIORITY_TRANSMIT_CACHE_CORE_MACROS_SVH
`define CAN_PRIORITY_TRANSMIT_CACHE_CORE_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset
`define CPTC_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cptc assertion failed");

// Same, on the block's own clock and reset
`define CPTC_ASSERT(lbl, prop) \
    `CPTC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

// ===== rtl/core/cptc_pkg.sv =====
// Package for the CAN priority transmit cache: constants, codes and the
// command/status structs between controller and datapath. No dependencies.
package cptc_pkg;

    // Sizing
    localparam int CACHE_SLOTS_DEF = 16;
    localparam int SLOT_W          = 11 + 4 + 64 + 8;
    localparam int PADDR_W         = 5;
    localparam int PDATA_W         = 32;

    // Identifier ranges
    localparam logic [10:0] NMT_ERR_MIN = 11'h701;
    localparam logic [10:0] NMT_ERR_MAX = 11'h77F;
    localparam logic [10:0] SDO_SC_MIN  = 11'h581;
    localparam logic [10:0] SDO_SC_MAX  = 11'h5FF;
    localparam logic [10:0] SDO_CS_MIN  = 11'h601;
    localparam logic [10:0] SDO_CS_MAX  = 11'h67F;

    // First slot of the lowest priority band, and link room cap per item
    localparam int          LOW_BAND_START = 4;
    localparam logic [4:0]  ROOM_CAP       = 5'd16;

    // Register indexes
    localparam logic [2:0] REG_OP_STATE     = 3'd0;
    localparam logic [2:0] REG_LINK_ENABLED = 3'd1;
    localparam logic [2:0] REG_BAND0_LIMIT  = 3'd2;
    localparam logic [2:0] REG_BAND1_LIMIT  = 3'd3;
    localparam logic [2:0] REG_BAND2_LIMIT  = 3'd4;
    localparam logic [2:0] REG_SDO_LAST     = 3'd5;

    // Register reset values
    localparam logic [1:0]  RST_OP_STATE   = 2'd0;
    localparam logic        RST_LINK_EN    = 1'b1;
    localparam logic [10:0] RST_BAND0      = 11'd127;
    localparam logic [10:0] RST_BAND1      = 11'd511;
    localparam logic [10:0] RST_BAND2      = 11'd1023;
    localparam logic        RST_SDO_LAST   = 1'b0;

    // Node states
    localparam logic [1:0] NODE_INIT    = 2'd0;
    localparam logic [1:0] NODE_STOPPED = 2'd1;

    // Item commands
    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // Result kinds and status codes
    localparam logic       KIND_FRAME      = 1'b0;
    localparam logic       KIND_STATUS     = 1'b1;
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_REFUSED  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]  op_state;
        logic        link_enabled;
        logic [10:0] band0_limit;
        logic [10:0] band1_limit;
        logic [10:0] band2_limit;
        logic        sdo_last_slot_only;
    } t_cfg;

    // Controller -> datapath
    typedef struct packed {
        logic       load_item;
        logic       idx_clr;
        logic       idx_start;
        logic       idx_inc;
        logic       store_wr;
        logic       clr_ready;
        logic       ram_rd;
        logic       room_dec;
        logic       out_frame;
        logic       out_status;
        logic [1:0] status;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_drain;
        logic refused;
        logic cur_ready;
        logic idx_last;
        logic room_zero;
        logic link_en;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/core/cptc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cptc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/cptc_regs.sv =====
// Configuration register file on an APB-style port.
// Depends on cptc_pkg for the register map, reset values and t_cfg.
module cptc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cptc_pkg::PADDR_W-1:0] paddr,
    input  logic [cptc_pkg::PDATA_W-1:0] pwdata,
    output logic [cptc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output cptc_pkg::t_cfg               o_cfg
);

    cptc_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.op_state           <= cptc_pkg::RST_OP_STATE;
            r_cfg.link_enabled       <= cptc_pkg::RST_LINK_EN;
            r_cfg.band0_limit        <= cptc_pkg::RST_BAND0;
            r_cfg.band1_limit        <= cptc_pkg::RST_BAND1;
            r_cfg.band2_limit        <= cptc_pkg::RST_BAND2;
            r_cfg.sdo_last_slot_only <= cptc_pkg::RST_SDO_LAST;
        end else if (wr_en) begin
            case (reg_idx)
                cptc_pkg::REG_OP_STATE:     r_cfg.op_state     <= pwdata[1:0];
                cptc_pkg::REG_LINK_ENABLED: r_cfg.link_enabled <= pwdata[0];
                cptc_pkg::REG_BAND0_LIMIT:  r_cfg.band0_limit  <= pwdata[10:0];
                cptc_pkg::REG_BAND1_LIMIT:  r_cfg.band1_limit  <= pwdata[10:0];
                cptc_pkg::REG_BAND2_LIMIT:  r_cfg.band2_limit  <= pwdata[10:0];
                cptc_pkg::REG_SDO_LAST:     r_cfg.sdo_last_slot_only <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        case (reg_idx)
            cptc_pkg::REG_OP_STATE:     prdata[1:0]  = r_cfg.op_state;
            cptc_pkg::REG_LINK_ENABLED: prdata[0]    = r_cfg.link_enabled;
            cptc_pkg::REG_BAND0_LIMIT:  prdata[10:0] = r_cfg.band0_limit;
            cptc_pkg::REG_BAND1_LIMIT:  prdata[10:0] = r_cfg.band1_limit;
            cptc_pkg::REG_BAND2_LIMIT:  prdata[10:0] = r_cfg.band2_limit;
            cptc_pkg::REG_SDO_LAST:     prdata[0]    = r_cfg.sdo_last_slot_only;
            default: ;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/cptc_ctrl.sv =====
// Controller state machine: sequences refusal check, slot store, drain,
// retry and final status. Depends on cptc_pkg for command/status structs.
module cptc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cptc_pkg::t_dp_sts i_sts,
    output cptc_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_STORE,
        S_DRAIN,
        S_READ,
        S_STATUS
    } t_state;

    t_state     r_state,   n_state;
    logic       r_again,   n_again;
    logic       r_retried, n_retried;
    logic [1:0] r_status,  n_status;

    // Next state and commands
    always_comb begin
        logic step;
        logic drain_end;
        step      = 1'b0;
        drain_end = 1'b0;
        n_state   = r_state;
        n_again   = r_again;
        n_retried = r_retried;
        n_status  = r_status;
        o_cmd        = '0;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_CHECK: begin
                n_again   = 1'b0;
                n_retried = 1'b0;
                if (!i_sts.is_drain && i_sts.refused) begin
                    n_status = cptc_pkg::STATUS_REFUSED;
                    n_state  = S_STATUS;
                end else if (!i_sts.is_drain) begin
                    n_status        = cptc_pkg::STATUS_OK;
                    o_cmd.idx_start = 1'b1;
                    n_state         = S_STORE;
                end else begin
                    n_status      = cptc_pkg::STATUS_OK;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_DRAIN;
                end
            end
            S_STORE: begin
                if (!i_sts.cur_ready) begin
                    o_cmd.store_wr = 1'b1;
                    o_cmd.idx_clr  = 1'b1;
                    n_again        = 1'b0;
                    n_state        = S_DRAIN;
                end else if (i_sts.idx_last) begin
                    if (r_retried) begin
                        n_status = cptc_pkg::STATUS_OVERFLOW;
                        n_state  = S_STATUS;
                    end else begin
                        // cache full: drain once, then try again
                        n_retried     = 1'b1;
                        n_again       = 1'b1;
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_DRAIN;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_sts.cur_ready && i_sts.link_en && i_sts.room_zero) begin
                    drain_end = 1'b1;
                end else if (i_sts.cur_ready && i_sts.link_en) begin
                    o_cmd.ram_rd    = 1'b1;
                    o_cmd.room_dec  = 1'b1;
                    o_cmd.clr_ready = 1'b1;
                    n_state         = S_READ;
                end else begin
                    // free slot, or discarded frame with the link off
                    o_cmd.clr_ready = i_sts.cur_ready;
                    step            = 1'b1;
                end
            end
            S_READ: begin
                if (i_sts.out_free) begin
                    o_cmd.out_frame = 1'b1;
                    step            = 1'b1;
                end
            end
            S_STATUS: begin
                if (i_sts.out_free) begin
                    o_cmd.out_status = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Advance the drain scan
        if (step) begin
            if (i_sts.idx_last) begin
                drain_end = 1'b1;
            end else begin
                o_cmd.idx_inc = 1'b1;
                n_state       = S_DRAIN;
            end
        end
        if (drain_end) begin
            if (r_again) begin
                n_again         = 1'b0;
                o_cmd.idx_start = 1'b1;
                n_state         = S_STORE;
            end else begin
                n_state = S_STATUS;
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_again   <= 1'b0;
            r_retried <= 1'b0;
            r_status  <= cptc_pkg::STATUS_OK;
            o_ready   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_again   <= n_again;
            r_retried <= n_retried;
            r_status  <= n_status;
            o_ready   <= (n_state == S_IDLE);
        end
    end

endmodule

// ===== rtl/core/cptc_dp.sv =====
// Datapath: item registers, slot ready bits, slot payload RAM, scan index,
// link room counter and output register. Depends on cptc_pkg and cptc_ram.
module cptc_dp #(
    parameter int CACHE_SLOTS = cptc_pkg::CACHE_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cptc_pkg::t_cfg    i_cfg,
    input  cptc_pkg::t_dp_cmd i_cmd,
    output cptc_pkg::t_dp_sts o_sts,
    input  logic              i_command,
    input  logic [10:0]       i_frame_id,
    input  logic [3:0]        i_frame_len,
    input  logic [63:0]       i_frame_data,
    input  logic [7:0]        i_frame_flags,
    input  logic [4:0]        i_link_room,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_kind,
    output logic [10:0]       o_out_id,
    output logic [3:0]        o_out_len,
    output logic [63:0]       o_out_data,
    output logic [7:0]        o_out_flags,
    output logic [1:0]        o_status,
    output logic              o_last
);

    localparam int IDX_W = $clog2(CACHE_SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_SLOTS - 1);

    // Item registers
    logic        r_cmd;
    logic [10:0] r_id;
    logic [3:0]  r_len;
    logic [63:0] r_data;
    logic [7:0]  r_flags;
    logic [4:0]  r_room;

    logic [IDX_W-1:0]       r_idx;
    logic [CACHE_SLOTS-1:0] r_ready;
    logic                   r_out_valid;

    logic [IDX_W-1:0]            start_idx;
    logic                        errctl;
    logic                        is_sdo;
    logic                        out_free;
    logic [cptc_pkg::SLOT_W-1:0] rd_word;

    // Capture the item; link room saturates for the whole item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd   <= i_command;
            r_id    <= i_frame_id;
            r_len   <= i_frame_len;
            r_data  <= i_frame_data;
            r_flags <= i_frame_flags;
            r_room  <= (i_link_room > cptc_pkg::ROOM_CAP) ? cptc_pkg::ROOM_CAP
                                                         : i_link_room;
        end else if (i_cmd.room_dec) begin
            r_room <= r_room - 5'd1;
        end
    end

    // Refusal and first allowed slot
    assign errctl = (r_id >= cptc_pkg::NMT_ERR_MIN) && (r_id <= cptc_pkg::NMT_ERR_MAX);
    assign is_sdo = ((r_id >= cptc_pkg::SDO_SC_MIN) && (r_id <= cptc_pkg::SDO_SC_MAX)) ||
                    ((r_id >= cptc_pkg::SDO_CS_MIN) && (r_id <= cptc_pkg::SDO_CS_MAX));

    always_comb begin
        if (i_cfg.sdo_last_slot_only && is_sdo) begin
            start_idx = IDX_LAST;
        end else if (r_id <= i_cfg.band0_limit) begin
            start_idx = IDX_W'(0);
        end else if (r_id <= i_cfg.band1_limit) begin
            start_idx = IDX_W'(1);
        end else if (r_id <= i_cfg.band2_limit) begin
            start_idx = IDX_W'(2);
        end else begin
            start_idx = IDX_W'(cptc_pkg::LOW_BAND_START);
        end
    end

    // Scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_start) begin
            r_idx <= start_idx;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Slot ready bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= '0;
        end else if (i_cmd.store_wr) begin
            r_ready[r_idx] <= 1'b1;
        end else if (i_cmd.clr_ready) begin
            r_ready[r_idx] <= 1'b0;
        end
    end

    // Slot payload store
    cptc_ram #(
        .WIDTH (cptc_pkg::SLOT_W),
        .DEPTH (CACHE_SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.store_wr),
        .i_wr_addr (r_idx),
        .i_wr_data ({r_id, r_len, r_data, r_flags}),
        .i_rd_en   (i_cmd.ram_rd),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_word)
    );

    // Output register
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_frame || i_cmd.out_status) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_frame) begin
            o_kind      <= cptc_pkg::KIND_FRAME;
            o_out_id    <= rd_word[86:76];
            o_out_len   <= rd_word[75:72];
            o_out_data  <= rd_word[71:8];
            o_out_flags <= rd_word[7:0];
            o_status    <= cptc_pkg::STATUS_OK;
            o_last      <= 1'b0;
        end else if (i_cmd.out_status) begin
            o_kind      <= cptc_pkg::KIND_STATUS;
            o_out_id    <= '0;
            o_out_len   <= '0;
            o_out_data  <= '0;
            o_out_flags <= '0;
            o_status    <= i_cmd.status;
            o_last      <= 1'b1;
        end
    end

    assign o_valid = r_out_valid;

    // Status to the controller
    assign o_sts.is_drain  = (r_cmd == cptc_pkg::CMD_DRAIN);
    assign o_sts.refused   = !errctl && ((i_cfg.op_state == cptc_pkg::NODE_INIT) ||
                                         (i_cfg.op_state == cptc_pkg::NODE_STOPPED));
    assign o_sts.cur_ready = r_ready[r_idx];
    assign o_sts.idx_last  = (r_idx == IDX_LAST);
    assign o_sts.room_zero = (r_room == 5'd0);
    assign o_sts.link_en   = i_cfg.link_enabled;
    assign o_sts.out_free  = out_free;

endmodule

// ===== rtl/core/can_priority_transmit_cache_core.sv =====
// Top level of the CAN priority transmit cache: registers, controller and
// datapath. Depends on cptc_pkg, cptc_regs, cptc_ctrl, cptc_dp, cptc_ram.
//
// Usage: one item enters on i_valid/o_ready: a submit (frame plus link room)
// or a drain-only command. Results leave on o_valid/i_ready from an output
// register: zero or more sent frames (kind 0) and then one status result
// (kind 1, o_last high). Configuration goes through the APB-style port and
// must be written by the user only while the block is idle; the block itself
// does not enforce this.
// Timing: one item is worked on at a time. A refused submit goes from the
// check straight to its status result. Otherwise a submit probes slots from
// its band's first slot for a free one, and then the drain scan visits the
// slots in order from slot 0, with a slot RAM read for each frame sent. A
// drain command runs the scan alone. A submit that finds the cache full
// drains and scans once more: it overflows if the cache is still full, and
// otherwise stores and drains again. The slot scan and the single slot RAM
// read port set the time per item.
// Reset (synchronous, active low) frees all slots and loads register
// defaults; slot payload is not cleared. A stalled receiver holds the output
// register, and the scan waits before loading the next frame.
module can_priority_transmit_cache_core #(
    parameter int CACHE_SLOTS = cptc_pkg::CACHE_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cptc_pkg::PADDR_W-1:0] paddr,
    input  logic [cptc_pkg::PDATA_W-1:0] pwdata,
    output logic [cptc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    // Input transactions
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_command,
    input  logic [10:0]                  i_frame_id,
    input  logic [3:0]                   i_frame_len,
    input  logic [63:0]                  i_frame_data,
    input  logic [7:0]                   i_frame_flags,
    input  logic [4:0]                   i_link_room,
    // Output transactions
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_kind,
    output logic [10:0]                  o_out_id,
    output logic [3:0]                   o_out_len,
    output logic [63:0]                  o_out_data,
    output logic [7:0]                   o_out_flags,
    output logic [1:0]                   o_status,
    output logic                         o_last
);

    cptc_pkg::t_cfg    cfg;
    cptc_pkg::t_dp_cmd dp_cmd;
    cptc_pkg::t_dp_sts dp_sts;

    cptc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cptc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    cptc_dp #(
        .CACHE_SLOTS (CACHE_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_command     (i_command),
        .i_frame_id    (i_frame_id),
        .i_frame_len   (i_frame_len),
        .i_frame_data  (i_frame_data),
        .i_frame_flags (i_frame_flags),
        .i_link_room   (i_link_room),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_out_id      (o_out_id),
        .o_out_len     (o_out_len),
        .o_out_data    (o_out_data),
        .o_out_flags   (o_out_flags),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

// ===== rtl/core/cptc_checker.sv =====
// Port-level checker for the transmit cache, bound to the top level.
// Depends on cptc_pkg and can_priority_transmit_cache_core_macros.svh.
`include "can_priority_transmit_cache_core_macros.svh"

module cptc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_kind,
    input logic [10:0] o_out_id,
    input logic [63:0] o_out_data,
    input logic [1:0]  o_status,
    input logic        o_last
);

    // Held result keeps its payload while the receiver stalls
    `CPTC_ASSERT(a_out_hold, (o_valid && !i_ready) |=> (o_valid && $stable(o_out_data) && $stable(o_last)))

    // One item at a time: the input closes right after a transaction
    `CPTC_ASSERT(a_busy_after_accept, (i_valid && o_ready) |=> !o_ready)

    // Sent frames carry ok status and never end the item
    `CPTC_ASSERT(a_frame_fields, (o_valid && o_kind == cptc_pkg::KIND_FRAME) |-> (o_status == cptc_pkg::STATUS_OK && !o_last))

    // The final result is a status result with a cleared identifier and a valid status code
    `CPTC_ASSERT(a_status_fields, (o_valid && o_last) |-> (o_kind == cptc_pkg::KIND_STATUS && o_out_id == 11'd0 && o_status != 2'd3))

endmodule

bind can_priority_transmit_cache_core cptc_checker u_cptc_checker (.*);

// ===== bench/can_priority_transmit_cache_core_checker.sv =====
// Scoreboard for the CAN priority transmit cache: follows register writes, predicts the
// result transactions of every accepted item and checks them in order.
// Depends on cptc_pkg only; it observes the core's ports and drives none of them.
`timescale 1ns / 100ps

module can_priority_transmit_cache_core_checker #(
    parameter int CACHE_SLOTS = cptc_pkg::CACHE_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cptc_pkg::PADDR_W-1:0] paddr,
    input  logic [cptc_pkg::PDATA_W-1:0] pwdata,
    input  logic                         pready,
    // Item channel
    input  logic                         i_valid,
    input  logic                         o_ready,
    input  logic                         i_command,
    input  logic [10:0]                  i_frame_id,
    input  logic [3:0]                   i_frame_len,
    input  logic [63:0]                  i_frame_data,
    input  logic [7:0]                   i_frame_flags,
    input  logic [4:0]                   i_link_room,
    // Result channel
    input  logic                         o_valid,
    input  logic                         i_ready,
    input  logic                         o_kind,
    input  logic [10:0]                  o_out_id,
    input  logic [3:0]                   o_out_len,
    input  logic [63:0]                  o_out_data,
    input  logic [7:0]                   o_out_flags,
    input  logic [1:0]                   o_status,
    input  logic                         o_last,
    // To the testbench top
    output int                           o_pending,
    output int                           o_fail_count,
    output int                           o_frames_sent,
    output int                           o_refusals,
    output int                           o_overflows
);

    typedef struct packed {
        logic        kind;
        logic [10:0] id;
        logic [3:0]  len;
        logic [63:0] data;
        logic [7:0]  flags;
        logic [1:0]  status;
        logic        last;
    } t_tx_result;

    // Mirror of the register file and the slot store
    cptc_pkg::t_cfg cfg;
    logic        slot_busy  [CACHE_SLOTS];
    logic [10:0] slot_ident [CACHE_SLOTS];
    logic [3:0]  slot_len   [CACHE_SLOTS];
    logic [63:0] slot_data  [CACHE_SLOTS];
    logic [7:0]  slot_flags [CACHE_SLOTS];
    logic [4:0]  link_credit;

    t_tx_result  results_due [$];
    t_tx_result  head;
    int          mismatches;
    int          frames_sent;
    int          refusals;
    int          overflows;

    assign o_fail_count  = mismatches;
    assign o_frames_sent = frames_sent;
    assign o_refusals    = refusals;
    assign o_overflows   = overflows;

    function automatic void push_result(logic kind, logic [10:0] id, logic [3:0] len,
                                        logic [63:0] data, logic [7:0] flags,
                                        logic [1:0] status);
        t_tx_result r;
        r.kind   = kind;
        r.id     = id;
        r.len    = len;
        r.data   = data;
        r.flags  = flags;
        r.status = status;
        r.last   = (kind == cptc_pkg::KIND_STATUS);
        results_due.push_back(r);
    endfunction

    // Walk the slots in order; stop at the first ready slot the link has no room for
    function automatic void drain_slots();
        int   s;
        logic blocked;
        blocked = 1'b0;
        s = 0;
        while (s < CACHE_SLOTS && !blocked) begin
            if (slot_busy[s]) begin
                if (cfg.link_enabled && link_credit == 5'd0) begin
                    blocked = 1'b1;
                end else begin
                    if (cfg.link_enabled) begin
                        link_credit = link_credit - 5'd1;
                        push_result(cptc_pkg::KIND_FRAME, slot_ident[s], slot_len[s],
                                    slot_data[s], slot_flags[s], cptc_pkg::STATUS_OK);
                        frames_sent++;
                    end
                    slot_busy[s] = 1'b0;
                end
            end
            s++;
        end
    endfunction

    // First free slot at or after the band's start point
    function automatic logic place_frame(int first, logic [10:0] id, logic [3:0] len,
                                         logic [63:0] data, logic [7:0] flags);
        int   s;
        logic done;
        done = 1'b0;
        for (s = first; s < CACHE_SLOTS && !done; s++) begin
            if (!slot_busy[s]) begin
                slot_ident[s] = id;
                slot_len[s]   = len;
                slot_data[s]  = data;
                slot_flags[s] = flags;
                slot_busy[s]  = 1'b1;
                done          = 1'b1;
            end
        end
        return done;
    endfunction

    function automatic void predict_item(logic cmd, logic [10:0] id, logic [3:0] len,
                                         logic [63:0] data, logic [7:0] flags,
                                         logic [4:0] room);
        logic [1:0] status;
        logic       err_ctl;
        logic       sdo;
        int         first;
        status      = cptc_pkg::STATUS_OK;
        link_credit = (room > cptc_pkg::ROOM_CAP) ? cptc_pkg::ROOM_CAP : room;
        if (cmd == cptc_pkg::CMD_DRAIN) begin
            drain_slots();
        end else begin
            err_ctl = (id >= cptc_pkg::NMT_ERR_MIN) && (id <= cptc_pkg::NMT_ERR_MAX);
            if (!err_ctl && (cfg.op_state == cptc_pkg::NODE_INIT ||
                             cfg.op_state == cptc_pkg::NODE_STOPPED)) begin
                refusals++;
                push_result(cptc_pkg::KIND_STATUS, 11'd0, 4'd0, 64'd0, 8'd0,
                            cptc_pkg::STATUS_REFUSED);
                return;
            end
            if (id <= cfg.band0_limit)      first = 0;
            else if (id <= cfg.band1_limit) first = 1;
            else if (id <= cfg.band2_limit) first = 2;
            else                            first = cptc_pkg::LOW_BAND_START;
            sdo = (id >= cptc_pkg::SDO_SC_MIN && id <= cptc_pkg::SDO_SC_MAX) ||
                  (id >= cptc_pkg::SDO_CS_MIN && id <= cptc_pkg::SDO_CS_MAX);
            if (cfg.sdo_last_slot_only && sdo) first = CACHE_SLOTS - 1;
            // Full cache: drain once, then one more try
            if (place_frame(first, id, len, data, flags)) begin
                drain_slots();
            end else begin
                drain_slots();
                if (place_frame(first, id, len, data, flags)) drain_slots();
                else status = cptc_pkg::STATUS_OVERFLOW;
            end
        end
        if (status == cptc_pkg::STATUS_OVERFLOW) overflows++;
        push_result(cptc_pkg::KIND_STATUS, 11'd0, 4'd0, 64'd0, 8'd0, status);
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Register writes, item predictions and result checks, all on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.op_state           = cptc_pkg::RST_OP_STATE;
            cfg.link_enabled       = cptc_pkg::RST_LINK_EN;
            cfg.band0_limit        = cptc_pkg::RST_BAND0;
            cfg.band1_limit        = cptc_pkg::RST_BAND1;
            cfg.band2_limit        = cptc_pkg::RST_BAND2;
            cfg.sdo_last_slot_only = cptc_pkg::RST_SDO_LAST;
            for (int s = 0; s < CACHE_SLOTS; s++) slot_busy[s] = 1'b0;
            results_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[cptc_pkg::PADDR_W-1:2])
                    cptc_pkg::REG_OP_STATE:     cfg.op_state           = pwdata[1:0];
                    cptc_pkg::REG_LINK_ENABLED: cfg.link_enabled       = pwdata[0];
                    cptc_pkg::REG_BAND0_LIMIT:  cfg.band0_limit        = pwdata[10:0];
                    cptc_pkg::REG_BAND1_LIMIT:  cfg.band1_limit        = pwdata[10:0];
                    cptc_pkg::REG_BAND2_LIMIT:  cfg.band2_limit        = pwdata[10:0];
                    cptc_pkg::REG_SDO_LAST:     cfg.sdo_last_slot_only = pwdata[0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                predict_item(i_command, i_frame_id, i_frame_len, i_frame_data,
                             i_frame_flags, i_link_room);
            end
            if (o_valid && i_ready) begin
                if (results_due.size() == 0) begin
                    $error("result transaction with nothing expected: kind %0d status %0d",
                           o_kind, o_status);
                    mismatches++;
                end else begin
                    head = results_due.pop_front();
                    compare_field("kind",      head.kind,   o_kind);
                    compare_field("out_id",    head.id,     o_out_id);
                    compare_field("out_len",   head.len,    o_out_len);
                    compare_field("out_data",  head.data,   o_out_data);
                    compare_field("out_flags", head.flags,  o_out_flags);
                    compare_field("status",    head.status, o_status);
                    compare_field("last",      head.last,   o_last);
                end
            end
        end
        o_pending <= results_due.size();
    end

endmodule

// ===== bench/can_priority_transmit_cache_core_tb.sv =====
// Testbench top for the CAN priority transmit cache: clock, reset, register writes,
// item and result traffic with random gaps, watchdog and verdict.
// Depends on cptc_pkg, can_priority_transmit_cache_core and its checker module.
`timescale 1ns / 100ps

module can_priority_transmit_cache_core_tb;

    localparam int         WATCHDOG_LIMIT   = 20000;
    localparam int         RANDOM_PHASES    = 6;
    localparam int         ITEMS_PER_PHASE  = 52;
    localparam int         SETTLE_CYCLES    = 60;
    localparam logic [1:0] NODE_OPERATIONAL = 2'd2;
    localparam logic [1:0] NODE_PREOP       = 2'd3;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [cptc_pkg::PADDR_W-1:0] paddr;
    logic [cptc_pkg::PDATA_W-1:0] pwdata;
    logic [cptc_pkg::PDATA_W-1:0] prdata;
    logic                         pready;
    logic                         i_valid;
    logic                         o_ready;
    logic                         i_command;
    logic [10:0]                  i_frame_id;
    logic [3:0]                   i_frame_len;
    logic [63:0]                  i_frame_data;
    logic [7:0]                   i_frame_flags;
    logic [4:0]                   i_link_room;
    logic                         o_valid;
    logic                         i_ready;
    logic                         o_kind;
    logic [10:0]                  o_out_id;
    logic [3:0]                   o_out_len;
    logic [63:0]                  o_out_data;
    logic [7:0]                   o_out_flags;
    logic [1:0]                   o_status;
    logic                         o_last;

    int   pending_results;
    int   fail_count;
    int   frames_sent;
    int   refusals;
    int   overflows;

    // Stimulus bookkeeping
    cptc_pkg::t_cfg cfg_written;
    logic source_eager = 1'b0;
    logic sink_eager   = 1'b0;
    int   items_sent   = 0;
    int   reg_writes   = 0;

    can_priority_transmit_cache_core DUT (.*);

    can_priority_transmit_cache_core_checker result_check (
        .*,
        .o_pending     (pending_results),
        .o_fail_count  (fail_count),
        .o_frames_sent (frames_sent),
        .o_refusals    (refusals),
        .o_overflows   (overflows)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [63:0] random_data();
        return {$urandom(), $urandom()};
    endfunction

    // Identifiers aimed at band edges, SDO and error-control ranges, and the extremes
    function automatic logic [10:0] random_id();
        int          r;
        int          which;
        logic [10:0] edge_id;
        r = $urandom_range(0, 99);
        which = $urandom_range(0, 2);
        if (r < 25) begin
            edge_id = (which == 0) ? cfg_written.band0_limit :
                      (which == 1) ? cfg_written.band1_limit : cfg_written.band2_limit;
            return edge_id + 11'($urandom_range(0, 2)) - 11'd1;
        end
        if (r < 40) begin
            if (which == 0)
                return 11'($urandom_range(cptc_pkg::SDO_SC_MIN, cptc_pkg::SDO_SC_MAX));
            if (which == 1)
                return 11'($urandom_range(cptc_pkg::SDO_CS_MIN, cptc_pkg::SDO_CS_MAX));
            return 11'($urandom_range(cptc_pkg::SDO_SC_MIN - 11'd1,
                                      cptc_pkg::SDO_CS_MAX + 11'd1));
        end
        if (r < 50)
            return 11'($urandom_range(cptc_pkg::NMT_ERR_MIN - 11'd1,
                                      cptc_pkg::NMT_ERR_MAX + 11'd1));
        if (r < 58) return (which == 0) ? 11'd0 : 11'h7ff;
        return 11'($urandom_range(0, 2047));
    endfunction

    // Small room keeps the cache filling up; sometimes above the cap
    function automatic logic [4:0] random_room();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 5'($urandom_range(0, 2));
        if (r < 85) return 5'($urandom_range(3, 16));
        return 5'($urandom_range(17, 31));
    endfunction

    function automatic logic [3:0] random_len();
        return ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
                                            : 4'($urandom_range(9, 15));
    endfunction

    function automatic cptc_pkg::t_cfg draw_settings(int phase_idx);
        cptc_pkg::t_cfg c;
        int             r;
        r = $urandom_range(0, 9);
        c.op_state     = (r < 6) ? NODE_OPERATIONAL : (r < 8) ? NODE_PREOP :
                         (r < 9) ? cptc_pkg::NODE_INIT : cptc_pkg::NODE_STOPPED;
        c.link_enabled = (phase_idx == 3) ? 1'b0 : ($urandom_range(0, 5) != 0);
        if (phase_idx == 0) begin
            c.band0_limit = 11'd0;
            c.band1_limit = 11'd0;
            c.band2_limit = 11'd0;
        end else if (phase_idx == RANDOM_PHASES - 1) begin
            c.band0_limit = 11'h7ff;
            c.band1_limit = 11'h7ff;
            c.band2_limit = 11'h7ff;
        end else if ($urandom_range(0, 3) == 0) begin
            // unordered limits
            c.band0_limit = 11'($urandom_range(0, 2047));
            c.band1_limit = 11'($urandom_range(0, 2047));
            c.band2_limit = 11'($urandom_range(0, 2047));
        end else begin
            c.band0_limit = 11'($urandom_range(0, 700));
            c.band1_limit = 11'($urandom_range(c.band0_limit, 1400));
            c.band2_limit = 11'($urandom_range(c.band1_limit, 2047));
        end
        c.sdo_last_slot_only = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // APB write: setup cycle, then access cycle
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            cptc_pkg::REG_OP_STATE:     cfg_written.op_state           = value[1:0];
            cptc_pkg::REG_LINK_ENABLED: cfg_written.link_enabled       = value[0];
            cptc_pkg::REG_BAND0_LIMIT:  cfg_written.band0_limit        = value[10:0];
            cptc_pkg::REG_BAND1_LIMIT:  cfg_written.band1_limit        = value[10:0];
            cptc_pkg::REG_BAND2_LIMIT:  cfg_written.band2_limit        = value[10:0];
            cptc_pkg::REG_SDO_LAST:     cfg_written.sdo_last_slot_only = value[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_config(cptc_pkg::t_cfg c);
        write_reg(cptc_pkg::REG_OP_STATE,     {30'd0, c.op_state});
        write_reg(cptc_pkg::REG_LINK_ENABLED, {31'd0, c.link_enabled});
        write_reg(cptc_pkg::REG_BAND0_LIMIT,  {21'd0, c.band0_limit});
        write_reg(cptc_pkg::REG_BAND1_LIMIT,  {21'd0, c.band1_limit});
        write_reg(cptc_pkg::REG_BAND2_LIMIT,  {21'd0, c.band2_limit});
        write_reg(cptc_pkg::REG_SDO_LAST,     {31'd0, c.sdo_last_slot_only});
    endtask

    // Hold off new items until every predicted result has come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_item(logic cmd, logic [10:0] id, logic [3:0] len,
                             logic [63:0] data, logic [7:0] flags, logic [4:0] room);
        int gap;
        gap = source_eager ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_frame_id    <= id;
        i_frame_len   <= len;
        i_frame_data  <= data;
        i_frame_flags <= flags;
        i_link_room   <= room;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    // Result side: random ready stalls unless the phase wants a free-running sink
    initial begin : sink_driver
        int hold;
        hold    = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold != 0) begin
                hold--;
            end else if (sink_eager) begin
                i_ready <= 1'b1;
            end else if (i_ready) begin
                i_ready <= 1'b0;
                hold    = pick_gap();
            end else begin
                i_ready <= 1'b1;
                hold    = $urandom_range(0, 6);
            end
        end
    end

    // Watchdog: too long without any transaction on any port
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || psel) idle_cycles = 0;
            else idle_cycles++;
        end
        $error("watchdog: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_results);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int   phase;
        int   n;
        int   directed_items;
        logic cmd;

        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_valid       = 1'b0;
        i_command     = cptc_pkg::CMD_SUBMIT;
        i_frame_id    = '0;
        i_frame_len   = '0;
        i_frame_data  = '0;
        i_frame_flags = '0;
        i_link_room   = '0;
        cfg_written.op_state           = cptc_pkg::RST_OP_STATE;
        cfg_written.link_enabled       = cptc_pkg::RST_LINK_EN;
        cfg_written.band0_limit        = cptc_pkg::RST_BAND0;
        cfg_written.band1_limit        = cptc_pkg::RST_BAND1;
        cfg_written.band2_limit        = cptc_pkg::RST_BAND2;
        cfg_written.sdo_last_slot_only = cptc_pkg::RST_SDO_LAST;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Node initialising: refused unless error-control, edges of that range
        send_item(cptc_pkg::CMD_SUBMIT, 11'h123, 4'd3, random_data(), 8'h5a, 5'd3);
        send_item(cptc_pkg::CMD_SUBMIT, cptc_pkg::NMT_ERR_MIN - 11'd1, 4'd8, random_data(),
                  8'h01, 5'd0);
        send_item(cptc_pkg::CMD_SUBMIT, cptc_pkg::NMT_ERR_MAX + 11'd1, 4'd8, random_data(),
                  8'h80, 5'd0);
        send_item(cptc_pkg::CMD_SUBMIT, cptc_pkg::NMT_ERR_MIN, 4'd0, 64'd0, 8'h00, 5'd0);
        send_item(cptc_pkg::CMD_SUBMIT, cptc_pkg::NMT_ERR_MAX, 4'd15, '1, 8'hff, 5'd1);
        send_item(cptc_pkg::CMD_DRAIN, 11'd0, 4'd0, 64'd0, 8'h00, 5'd31);
        wait_idle();

        // Stopped node; room above the cap
        write_reg(cptc_pkg::REG_OP_STATE, {30'd0, cptc_pkg::NODE_STOPPED});
        send_item(cptc_pkg::CMD_SUBMIT, 11'd0, 4'd8, random_data(), 8'h3c, 5'd16);
        send_item(cptc_pkg::CMD_SUBMIT, 11'h740, 4'd8, random_data(), 8'hc3, 5'd17);
        wait_idle();

        // SDO frames confined to the last slot: overflow with and without a drain output
        write_reg(cptc_pkg::REG_OP_STATE, {30'd0, NODE_OPERATIONAL});
        write_reg(cptc_pkg::REG_SDO_LAST, 32'd1);
        send_item(cptc_pkg::CMD_SUBMIT, cptc_pkg::SDO_SC_MIN, 4'd8, random_data(), 8'h11, 5'd0);
        send_item(cptc_pkg::CMD_SUBMIT, cptc_pkg::SDO_CS_MAX, 4'd8, random_data(), 8'h22, 5'd0);
        send_item(cptc_pkg::CMD_SUBMIT, cptc_pkg::SDO_CS_MIN - 11'd1, 4'd4, random_data(),
                  8'h33, 5'd0);
        send_item(cptc_pkg::CMD_SUBMIT, cptc_pkg::SDO_SC_MAX, 4'd8, random_data(), 8'h44, 5'd1);
        send_item(cptc_pkg::CMD_SUBMIT, cptc_pkg::SDO_SC_MIN - 11'd1, 4'd9, random_data(),
                  8'h55, 5'd0);
        send_item(cptc_pkg::CMD_SUBMIT, 11'd0, 4'd8, '1, 8'hff, 5'd0);
        send_item(cptc_pkg::CMD_SUBMIT, 11'h7ff, 4'd15, 64'd0, 8'h00, 5'd0);
        send_item(cptc_pkg::CMD_DRAIN, 11'h7ff, 4'd15, '1, 8'hff, 5'd0);
        send_item(cptc_pkg::CMD_DRAIN, 11'd0, 4'd0, 64'd0, 8'h00, 5'd16);
        wait_idle();

        // Link off, all bands at zero: frames dropped without using room
        write_reg(cptc_pkg::REG_LINK_ENABLED, 32'd0);
        write_reg(cptc_pkg::REG_OP_STATE, {30'd0, NODE_PREOP});
        write_reg(cptc_pkg::REG_BAND0_LIMIT, 32'd0);
        write_reg(cptc_pkg::REG_BAND1_LIMIT, 32'd0);
        write_reg(cptc_pkg::REG_BAND2_LIMIT, 32'd0);
        send_item(cptc_pkg::CMD_SUBMIT, 11'd0, 4'd15, '1, 8'hff, 5'd5);
        send_item(cptc_pkg::CMD_SUBMIT, 11'h400, 4'd2, random_data(), 8'h0f, 5'd0);
        send_item(cptc_pkg::CMD_DRAIN, 11'd0, 4'd0, 64'd0, 8'h00, 5'd0);
        wait_idle();

        // Link back on, all bands at the top, SDO rule off
        write_reg(cptc_pkg::REG_LINK_ENABLED, 32'd1);
        write_reg(cptc_pkg::REG_BAND0_LIMIT, 32'h7ff);
        write_reg(cptc_pkg::REG_BAND1_LIMIT, 32'h7ff);
        write_reg(cptc_pkg::REG_BAND2_LIMIT, 32'h7ff);
        write_reg(cptc_pkg::REG_SDO_LAST, 32'd0);
        send_item(cptc_pkg::CMD_SUBMIT, cptc_pkg::SDO_CS_MIN + 11'd4, 4'd8, random_data(),
                  8'ha5, 5'd2);
        directed_items = items_sent;

        // Random phases, each under its own register setting
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            apply_config(draw_settings(phase));
            source_eager = (phase == 2);
            sink_eager   = (phase == 4);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 49) == 0) wait_idle();
                cmd = ($urandom_range(0, 9) == 0) ? cptc_pkg::CMD_DRAIN : cptc_pkg::CMD_SUBMIT;
                send_item(cmd, random_id(), random_len(), random_data(),
                          8'($urandom_range(0, 255)), random_room());
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items (%0d directed) and %0d register writes",
                 items_sent, directed_items, reg_writes);
        $display("  %0d frames to link, %0d refused submits, %0d cache overflows",
                 frames_sent, refusals, overflows);
        if (fail_count == 0 && pending_results == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (pending_results != 0)
                $error("%0d expected results never arrived", pending_results);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cptc_pkg.sv
rtl/core/cptc_ram.sv
rtl/core/cptc_regs.sv
rtl/core/cptc_ctrl.sv
rtl/core/cptc_dp.sv
rtl/core/can_priority_transmit_cache_core.sv
rtl/core/cptc_checker.sv
bench/can_priority_transmit_cache_core_checker.sv
bench/can_priority_transmit_cache_core_tb.sv
